[sv/float_matrix_multiply_macros.svh]
// Assertion macros for the float matrix multiply checker.
`ifndef FLOAT_MATRIX_MULTIPLY_MACROS_SVH
`define FLOAT_MATRIX_MULTIPLY_MACROS_SVH

// The condition in pre implies post in the same cycle.
`define FMM_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("fmm assertion failed");

// The condition in pre implies post in the next cycle.
`define FMM_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("fmm assertion failed");

`endif

[sv/fmm_pkg.sv]
// Package: payload types, codes and datapath structs of the float matrix multiply.
`timescale 1ns / 1ps

package fmm_pkg;

	// Store dimension: rows and columns of each element store.
	localparam int MAX_DIM = 16;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  row;
		logic [3:0]  col;
		logic [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [31:0] product;
		logic [3:0]  out_row;
		logic [3:0]  out_col;
		logic        range_error;
	} out_item_t;

	localparam logic [1:0] KIND_WRITE_A = 2'd0;
	localparam logic [1:0] KIND_WRITE_B = 2'd1;
	localparam logic [1:0] KIND_COMPUTE = 2'd2;

	localparam logic [1:0] REG_ROWS_M  = 2'd0;
	localparam logic [1:0] REG_INNER_K = 2'd1;
	localparam logic [1:0] REG_COLS_N  = 2'd2;

	localparam logic [31:0] FP_QNAN    = 32'h7FC0_0000;
	localparam logic [31:0] FP_INF_MAG = 32'h7F80_0000;

	// Request to the shared normalize/round unit: value = mant * 2^expo.
	typedef struct packed {
		logic               special;
		logic [31:0]        special_bits;
		logic               sign;
		logic [47:0]        mant;
		logic signed [10:0] expo;
	} rnd_req_t;

	// Shift plan from the normalize step.
	typedef struct packed {
		logic        special;
		logic [31:0] special_bits;
		logic        sign;
		logic [47:0] mant;
		logic        left;
		logic [5:0]  amt;
		logic [8:0]  base;
	} norm_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MULT,
		ST_NORM,
		ST_PACK,
		ST_ALIGN,
		ST_EMIT
	} state_t;

endpackage

[sv/fmm_mul.sv]
// Binary32 multiply front end: special operands and exact significand product.
`timescale 1ns / 1ps

module fmm_mul import fmm_pkg::*; (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output rnd_req_t    req
);

	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
	logic [23:0] ma, mb;
	logic [8:0]  ea, eb;

	always_comb begin
		a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		sgn    = a[31] ^ b[31];
		ma     = {a[30:23] != 8'd0, a[22:0]};
		mb     = {b[30:23] != 8'd0, b[22:0]};
		ea     = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
		eb     = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};

		req.sign = sgn;
		req.mant = ma * mb;
		req.expo = $signed({2'b00, ea}) + $signed({2'b00, eb}) - 11'sd300;

		req.special      = 1'b1;
		req.special_bits = 32'd0;
		if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
			req.special_bits = FP_QNAN;
		end else if (a_inf || b_inf) begin
			req.special_bits = {sgn, FP_INF_MAG[30:0]};
		end else if (a_zero || b_zero) begin
			req.special_bits = {sgn, 31'd0};
		end else begin
			req.special = 1'b0;
		end
	end

endmodule

[sv/fmm_align.sv]
// Binary32 add front end: special operands, operand swap, alignment with sticky.
`timescale 1ns / 1ps

module fmm_align import fmm_pkg::*; (
	input  logic [31:0] x,
	input  logic [31:0] y,
	output rnd_req_t    req
);

	logic        x_nan, y_nan, x_inf, y_inf, x_zero, y_zero, swap;
	logic [23:0] mx, my, big_m, sm_m;
	logic [7:0]  ex, ey, big_e, sm_e, d;
	logic        big_s, sm_s;
	logic [26:0] small_w, small_sh;
	logic [27:0] sum;

	always_comb begin
		x_nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
		y_nan  = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
		x_inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
		y_inf  = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
		x_zero = (x[30:0] == 31'd0);
		y_zero = (y[30:0] == 31'd0);
		mx     = {x[30:23] != 8'd0, x[22:0]};
		my     = {y[30:23] != 8'd0, y[22:0]};
		ex     = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey     = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];

		// Larger magnitude goes first.
		swap  = (ex < ey) || ((ex == ey) && (mx < my));
		big_m = swap ? my : mx;
		big_e = swap ? ey : ex;
		big_s = swap ? y[31] : x[31];
		sm_m  = swap ? mx : my;
		sm_e  = swap ? ex : ey;
		sm_s  = swap ? x[31] : y[31];
		d     = big_e - sm_e;

		// Three extra bits: guard, round and a jammed sticky bit.
		small_w = {sm_m, 3'b000};
		if (d >= 8'd27) begin
			small_sh = 27'd1;
		end else begin
			small_sh    = small_w >> d;
			small_sh[0] = small_sh[0] | ((small_w & ((27'd1 << d) - 27'd1)) != 27'd0);
		end

		if (big_s == sm_s) begin
			sum = {1'b0, big_m, 3'b000} + {1'b0, small_sh};
		end else begin
			sum = {1'b0, big_m, 3'b000} - {1'b0, small_sh};
		end

		// Exact cancellation gives +0 under round to nearest.
		req.sign = (sum == 28'd0) ? 1'b0 : big_s;
		req.mant = {20'd0, sum};
		req.expo = $signed({3'b000, big_e}) - 11'sd153;

		req.special      = 1'b1;
		req.special_bits = 32'd0;
		if (x_nan || y_nan || (x_inf && y_inf && (x[31] != y[31]))) begin
			req.special_bits = FP_QNAN;
		end else if (x_inf) begin
			req.special_bits = x;
		end else if (y_inf) begin
			req.special_bits = y;
		end else if (x_zero && y_zero) begin
			req.special_bits = {x[31] & y[31], 31'd0};
		end else if (x_zero) begin
			req.special_bits = y;
		end else if (y_zero) begin
			req.special_bits = x;
		end else begin
			req.special = 1'b0;
		end
	end

endmodule

[sv/fmm_norm.sv]
// Normalize step of the shared rounder: leading-zero count and shift plan.
`timescale 1ns / 1ps

module fmm_norm import fmm_pkg::*; (
	input  rnd_req_t req,
	output norm_t    nrm
);

	logic [63:0]        v;
	logic [5:0]         lz;
	logic signed [11:0] be, shv, rsh;

	always_comb begin
		// Binary search for the leading one; the padding ends the search.
		v  = {req.mant, 16'hFFFF};
		lz = 6'd0;
		if (v[63:32] == 32'd0) begin lz[5] = 1'b1; v = v << 32; end
		if (v[63:48] == 16'd0) begin lz[4] = 1'b1; v = v << 16; end
		if (v[63:56] == 8'd0)  begin lz[3] = 1'b1; v = v << 8;  end
		if (v[63:60] == 4'd0)  begin lz[2] = 1'b1; v = v << 4;  end
		if (v[63:62] == 2'd0)  begin lz[1] = 1'b1; v = v << 2;  end
		if (v[63] == 1'b0)     begin lz[0] = 1'b1; end

		be  = 12'sd174 - $signed({6'd0, lz}) + $signed({req.expo[10], req.expo});
		shv = $signed({6'd0, lz}) - (12'sd1 - be);
		rsh = -shv;

		nrm.special      = req.special;
		nrm.special_bits = req.special_bits;
		nrm.sign         = req.sign;
		nrm.mant         = req.mant;
		if (be >= 12'sd1) begin
			nrm.left = 1'b1;
			nrm.amt  = lz;
			nrm.base = be[8:0] - 9'd1;
		end else if (shv >= 12'sd0) begin
			// Subnormal result: hold the point at the minimum exponent.
			nrm.left = 1'b1;
			nrm.amt  = shv[5:0];
			nrm.base = 9'd0;
		end else begin
			nrm.left = 1'b0;
			nrm.amt  = (rsh > 12'sd48) ? 6'd48 : rsh[5:0];
			nrm.base = 9'd0;
		end

		if (!req.special && (req.mant == 48'd0)) begin
			nrm.special      = 1'b1;
			nrm.special_bits = {req.sign, 31'd0};
		end
	end

endmodule

[sv/fmm_pack.sv]
// Pack step of the shared rounder: shift, round to nearest even, overflow.
`timescale 1ns / 1ps

module fmm_pack import fmm_pkg::*; (
	input  norm_t       nrm,
	output logic [31:0] res
);

	logic [95:0] t;
	logic [23:0] kept;
	logic        g, st, inc;
	logic [24:0] qr;
	logic [32:0] sum;

	always_comb begin
		t    = {nrm.mant, 48'd0};
		t    = nrm.left ? (t << nrm.amt) : (t >> nrm.amt);
		kept = t[95:72];
		g    = t[71];
		st   = |t[70:0];
		inc  = g & (st | kept[0]);
		qr   = {1'b0, kept} + {24'd0, inc};
		// Hidden bit and rounding carry ripple into the exponent field.
		sum  = {1'b0, nrm.base, 23'd0} + {8'd0, qr};

		if (nrm.special) begin
			res = nrm.special_bits;
		end else if (sum >= {1'b0, FP_INF_MAG}) begin
			res = {nrm.sign, FP_INF_MAG[30:0]};
		end else begin
			res = {nrm.sign, sum[30:0]};
		end
	end

endmodule

[sv/float_matrix_multiply.sv]
// Top level: element stores, term sequencer and shared binary32 multiply-add datapath.
//
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   in_data   (kind, row, col, value)
// out       output     out_valid / out_stall out_data  (product, out_row, out_col, range_error)
// cfg       input      cfg_we                cfg_index, cfg_data
//
// In-range write: stored, no result.
// Out-of-range item: accept, then the emit state, then a single error result.
// Compute: for each of K = effective inner_k terms, a store read, multiply, normalize,
// pack, align, normalize and pack through one rounder; then the emit state.
// Reset clears control and sets the size registers to 1; the stores are not cleared.
// A stalled output holds; new items are taken while a result waits to transfer.
`timescale 1ns / 1ps

module float_matrix_multiply import fmm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	logic [31:0] a_mem [DEPTH];
	logic [31:0] b_mem [DEPTH];

	state_t      state_q, state_d;
	logic [4:0]  rows_q, inner_q, cols_q;
	logic [4:0]  m_eff, k_eff, n_eff;
	logic [3:0]  i_q, j_q;
	logic [4:0]  k_q;
	logic        add_phase_q;
	logic [31:0] a_rd_q, b_rd_q, acc_q, prod_q;
	rnd_req_t    rq_q, mul_req, aln_req;
	norm_t       nm_q, nrm;
	logic [31:0] pk_res;
	logic [3:0]  res_row_q, res_col_q;
	logic        res_err_q;
	out_item_t   out_q;
	logic        out_valid_q;

	logic          ok_a, ok_b, ok_c, last_term;
	logic          we_a, we_b, go_err, go_cmp, emit;
	logic [AW-1:0] wr_addr, a_rd_addr, b_rd_addr;
	logic [31:0]   canon;

	// Sizes above the store dimension act as the store dimension.
	assign m_eff = (int'(rows_q) > MAX_DIM) ? 5'(MAX_DIM) : rows_q;
	assign k_eff = (int'(inner_q) > MAX_DIM) ? 5'(MAX_DIM) : inner_q;
	assign n_eff = (int'(cols_q) > MAX_DIM) ? 5'(MAX_DIM) : cols_q;

	assign ok_a = ({1'b0, in_data.row} < m_eff) && ({1'b0, in_data.col} < k_eff);
	assign ok_b = ({1'b0, in_data.row} < k_eff) && ({1'b0, in_data.col} < n_eff);
	assign ok_c = ({1'b0, in_data.row} < m_eff) && ({1'b0, in_data.col} < n_eff);

	assign wr_addr   = AW'(int'(in_data.row) * MAX_DIM + int'(in_data.col));
	assign a_rd_addr = AW'(int'(i_q) * MAX_DIM + int'(k_q));
	assign b_rd_addr = AW'(int'(k_q) * MAX_DIM + int'(j_q));

	assign last_term = ((k_q + 5'd1) == k_eff);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Shared arithmetic: multiply and add front ends feed one two-step rounder.
	fmm_mul   u_mul   (.a(a_rd_q), .b(b_rd_q), .req(mul_req));
	fmm_align u_align (.x(acc_q), .y(prod_q), .req(aln_req));
	fmm_norm  u_norm  (.req(rq_q), .nrm(nrm));
	fmm_pack  u_pack  (.nrm(nm_q), .res(pk_res));

	// Sequencer: next state and strobes.
	always_comb begin
		state_d = state_q;
		we_a    = 1'b0;
		we_b    = 1'b0;
		go_err  = 1'b0;
		go_cmp  = 1'b0;
		emit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_data.kind)
						KIND_WRITE_A: begin
							if (ok_a) begin
								we_a = 1'b1;
							end else begin
								go_err  = 1'b1;
								state_d = ST_EMIT;
							end
						end
						KIND_WRITE_B: begin
							if (ok_b) begin
								we_b = 1'b1;
							end else begin
								go_err  = 1'b1;
								state_d = ST_EMIT;
							end
						end
						KIND_COMPUTE: begin
							if (ok_c) begin
								go_cmp  = 1'b1;
								// Empty inner dimension: the sum stays +0.
								state_d = (k_eff == 5'd0) ? ST_EMIT : ST_READ;
							end else begin
								go_err  = 1'b1;
								state_d = ST_EMIT;
							end
						end
						default: begin
							// Unused kind: drop the item.
						end
					endcase
				end
			end
			ST_READ:  state_d = ST_MULT;
			ST_MULT:  state_d = ST_NORM;
			ST_NORM:  state_d = ST_PACK;
			ST_PACK: begin
				if (!add_phase_q) begin
					state_d = ST_ALIGN;
				end else if (last_term) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_ALIGN: state_d = ST_NORM;
			ST_EMIT: begin
				// Load the output only once the previous result has transferred.
				if (!out_valid_q || !out_stall) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= 5'd0;
			add_phase_q <= 1'b0;
			out_valid_q <= 1'b0;
			rows_q      <= 5'd1;
			inner_q     <= 5'd1;
			cols_q      <= 5'd1;
		end else begin
			state_q <= state_d;

			if (go_cmp) begin
				k_q         <= 5'd0;
				add_phase_q <= 1'b0;
			end else if (state_q == ST_ALIGN) begin
				add_phase_q <= 1'b1;
			end else if ((state_q == ST_PACK) && add_phase_q) begin
				add_phase_q <= 1'b0;
				k_q         <= k_q + 5'd1;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS_M:  rows_q  <= cfg_data;
					REG_INNER_K: inner_q <= cfg_data;
					REG_COLS_N:  cols_q  <= cfg_data;
					default: begin
						// No register at this index.
					end
				endcase
			end
		end
	end

	// Element stores: one write port, one registered read port each.
	always_ff @(posedge clk) begin
		if (we_a) begin
			a_mem[wr_addr] <= in_data.value;
		end
		if (state_q == ST_READ) begin
			a_rd_q <= a_mem[a_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			b_mem[wr_addr] <= in_data.value;
		end
		if (state_q == ST_READ) begin
			b_rd_q <= b_mem[b_rd_addr];
		end
	end

	// Any NaN leaves as the canonical quiet NaN.
	assign canon = ((acc_q[30:23] == 8'hFF) && (acc_q[22:0] != 23'd0)) ? FP_QNAN : acc_q;

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (go_cmp || go_err) begin
			res_row_q <= in_data.row;
			res_col_q <= in_data.col;
			res_err_q <= go_err;
			acc_q     <= 32'd0;
		end
		if (go_cmp) begin
			i_q <= in_data.row;
			j_q <= in_data.col;
		end
		case (state_q)
			ST_MULT:  rq_q <= mul_req;
			ST_ALIGN: rq_q <= aln_req;
			ST_NORM:  nm_q <= nrm;
			ST_PACK: begin
				if (add_phase_q) begin
					acc_q <= pk_res;
				end else begin
					prod_q <= pk_res;
				end
			end
			default: begin
				// Hold.
			end
		endcase
		if (emit) begin
			out_q.product     <= res_err_q ? 32'd0 : canon;
			out_q.out_row     <= res_row_q;
			out_q.out_col     <= res_col_q;
			out_q.range_error <= res_err_q;
		end
	end

endmodule

[sv/fmm_checker.sv]
// Port-level checker for the float matrix multiply, bound to the top level.
`timescale 1ns / 1ps
`include "float_matrix_multiply_macros.svh"

module fmm_checker import fmm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	`FMM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`FMM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
	`FMM_ASSERT_NOW(a_err_zero, out_valid && out_data.range_error, out_data.product == 32'd0)
	`FMM_ASSERT_NEXT(a_cmp_busy, in_valid && !in_stall && (in_data.kind == KIND_COMPUTE), in_stall)

endmodule

bind float_matrix_multiply fmm_checker u_fmm_checker (.*);

[tb/sv/testbench.sv]
// Testbench for float_matrix_multiply: directed and random stimulus checked against a binary32 predictor.
`timescale 1ns / 1ps

module testbench;
	import fmm_pkg::*;

	// Codes that the package does not name; the block ignores them.
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED  = 2'd3;
	localparam int         DIM         = MAX_DIM;
	localparam int         DRAIN_CYCLES = 150;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_we;
	logic [1:0] cfg_index;
	logic [4:0] cfg_data;

	float_matrix_multiply dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the block: element stores and size registers.
	logic [31:0] a_elems [DIM*DIM];
	logic [31:0] b_elems [DIM*DIM];
	logic [4:0]  size_m, size_k, size_n;

	out_item_t pending_products[$];
	int        error_count;
	bit        steady;       // no idling on either side while set
	bit        hold_output;  // receiver holds off while set

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net: far beyond the slowest correct run.
	initial begin
		#30ms;
		$display("Test completed with failures");
		$finish;
	end

	// ---------------------------------------------------------------
	// binary32 arithmetic, round to nearest even
	// ---------------------------------------------------------------

	// Round sign * mag * 2^e to binary32.
	function automatic logic [31:0] round_to_single(bit s, logic [299:0] mag, int e);
		int p, sh, be;
		logic [299:0] kept;
		bit rb, st;
		if (mag == '0) return {s, 31'b0};
		p = 299;
		while (!mag[p]) p--;
		// Normal results keep 24 bits; subnormals are quantized at 2^-149.
		if (p + e + 127 >= 1) sh = p - 23;
		else sh = -149 - e;
		if (sh <= 0) begin
			kept = mag << (-sh);
			rb = 1'b0;
			st = 1'b0;
		end else begin
			kept = mag >> sh;
			rb = mag[sh-1];
			st = ((mag << (301 - sh)) != '0);
		end
		if (rb && (st || kept[0])) kept = kept + 1;
		if (p + e + 127 >= 1) begin
			be = p + e + 127;
			if (kept[24]) begin
				kept = kept >> 1;
				be++;
			end
			if (be >= 255) return {s, 8'hFF, 23'b0};
			return {s, be[7:0], kept[22:0]};
		end
		// A subnormal that rounds up to 2^23 lands on the smallest normal.
		return {s, kept[30:0]};
	endfunction

	function automatic bit is_nan(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] != '0;
	endfunction

	function automatic bit is_inf(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] == '0;
	endfunction

	function automatic bit is_zero(logic [31:0] x);
		return x[30:0] == '0;
	endfunction

	function automatic int unbiased(logic [31:0] x);
		return (x[30:23] == 8'h00 ? 1 : int'(x[30:23])) - 150;
	endfunction

	function automatic logic [299:0] significand(logic [31:0] x);
		logic [299:0] r;
		r = '0;
		r[23:0] = {x[30:23] != 8'h00, x[22:0]};
		return r;
	endfunction

	function automatic logic [31:0] single_mul(logic [31:0] x, logic [31:0] y);
		bit s;
		s = x[31] ^ y[31];
		if (is_nan(x) || is_nan(y)) return FP_QNAN;
		if (is_inf(x) || is_inf(y)) begin
			if (is_zero(x) || is_zero(y)) return FP_QNAN;
			return {s, 31'b0} | FP_INF_MAG;
		end
		if (is_zero(x) || is_zero(y)) return {s, 31'b0};
		return round_to_single(s, significand(x) * significand(y), unbiased(x) + unbiased(y));
	endfunction

	function automatic logic [31:0] single_add(logic [31:0] x, logic [31:0] y);
		int ex, ey, emin;
		logic [299:0] mx, my, sum;
		bit s;
		if (is_nan(x) || is_nan(y)) return FP_QNAN;
		if (is_inf(x) && is_inf(y)) return (x[31] != y[31]) ? FP_QNAN : x;
		if (is_inf(x)) return x;
		if (is_inf(y)) return y;
		if (is_zero(x) && is_zero(y)) return {x[31] & y[31], 31'b0};
		if (is_zero(x)) return y;
		if (is_zero(y)) return x;
		ex = unbiased(x);
		ey = unbiased(y);
		emin = (ex < ey) ? ex : ey;
		mx = significand(x) << (ex - emin);
		my = significand(y) << (ey - emin);
		if (x[31] == y[31]) begin
			sum = mx + my;
			s = x[31];
		end else if (mx > my) begin
			sum = mx - my;
			s = x[31];
		end else if (my > mx) begin
			sum = my - mx;
			s = y[31];
		end else begin
			return 32'h0;  // exact cancellation gives +0
		end
		return round_to_single(s, sum, emin);
	endfunction

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	function automatic int clamp_size(logic [4:0] v);
		return (v > DIM) ? DIM : int'(v);
	endfunction

	function automatic logic [31:0] dot_product(int i, int j, int kk);
		logic [31:0] acc;
		acc = 32'h0;
		for (int k = 0; k < kk; k++)
			acc = single_add(acc, single_mul(a_elems[i*DIM + k], b_elems[k*DIM + j]));
		return is_nan(acc) ? FP_QNAN : acc;
	endfunction

	// Apply one transfer to the shadow stores; return 1 with the product if it yields one.
	function automatic bit predict_product(in_item_t it, output out_item_t r);
		int m, kk, n;
		bit ok;
		m  = clamp_size(size_m);
		kk = clamp_size(size_k);
		n  = clamp_size(size_n);
		r = '0;
		if (it.kind == KIND_UNUSED) return 1'b0;
		case (it.kind)
			KIND_WRITE_A: ok = it.row < m && it.col < kk;
			KIND_WRITE_B: ok = it.row < kk && it.col < n;
			default:      ok = it.row < m && it.col < n;
		endcase
		if (it.kind != KIND_COMPUTE && ok) begin
			if (it.kind == KIND_WRITE_A) a_elems[it.row*DIM + it.col] = it.value;
			else b_elems[it.row*DIM + it.col] = it.value;
			return 1'b0;
		end
		r.product     = ok ? dot_product(it.row, it.col, kk) : 32'h0;
		r.out_row     = it.row;
		r.out_col     = it.col;
		r.range_error = !ok;
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// driving and checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $realtime);
		error_count++;
	endtask

	// Offer one item and hold it until the transfer.
	task automatic send_item(logic [1:0] kind, logic [3:0] row, logic [3:0] col,
			logic [31:0] value);
		in_item_t it;
		out_item_t r;
		bit stalled;
		it = '{kind: kind, row: row, col: col, value: value};
		if (!steady && $urandom_range(0, 99) < 37) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do begin
			@(negedge clk);
			stalled = in_stall;
			if (!stalled && predict_product(it, r)) pending_products.push_back(r);
			@(posedge clk);
		end while (stalled);
	endtask

	task automatic go_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Write one size register once the block has drained.
	task automatic write_size(logic [1:0] index, logic [4:0] value);
		go_quiet();
		while (pending_products.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			REG_ROWS_M:  size_m = value;
			REG_INNER_K: size_k = value;
			REG_COLS_N:  size_n = value;
			default: ;
		endcase
	endtask

	task automatic set_sizes(logic [4:0] m, logic [4:0] k, logic [4:0] n);
		write_size(REG_ROWS_M, m);
		write_size(REG_INNER_K, k);
		write_size(REG_COLS_N, n);
	endtask

	// Binary32 pattern drawn from classes that stress rounding and specials.
	function automatic logic [31:0] random_single();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: ;
			1: v[30:0] = '0;
			2: v[30:0] = FP_INF_MAG[30:0];
			3: begin
				v[30:23] = 8'hFF;
				if (v[22:0] == '0) v[0] = 1'b1;
			end
			4: v[30:23] = 8'h00;
			5: v[30:23] = 8'($urandom_range(240, 254));
			6: v[30:23] = 8'($urandom_range(1, 12));
			default: v[30:23] = 8'($urandom_range(110, 144));
		endcase
		return v;
	endfunction

	// Write every element that a compute within the current sizes reads.
	task automatic fill_operands();
		int m, kk, n;
		m  = clamp_size(size_m);
		kk = clamp_size(size_k);
		n  = clamp_size(size_n);
		for (int i = 0; i < m; i++)
			for (int k = 0; k < kk; k++)
				send_item(KIND_WRITE_A, 4'(i), 4'(k), random_single());
		for (int k = 0; k < kk; k++)
			for (int j = 0; j < n; j++)
				send_item(KIND_WRITE_B, 4'(k), 4'(j), random_single());
	endtask

	// Check each result at the edge where it transfers.
	always @(negedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_products.size() == 0) begin
				report_mismatch("unexpected result", out_data.product, 32'h0);
			end else begin
				want = pending_products.pop_front();
				if (out_data.product !== want.product)
					report_mismatch("product", out_data.product, want.product);
				if (out_data.out_row !== want.out_row)
					report_mismatch("out_row", 32'(out_data.out_row), 32'(want.out_row));
				if (out_data.out_col !== want.out_col)
					report_mismatch("out_col", 32'(out_data.out_col), 32'(want.out_col));
				if (out_data.range_error !== want.range_error)
					report_mismatch("range_error", 32'(out_data.range_error),
						32'(want.range_error));
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when asked.
	always @(posedge clk) begin
		out_stall <= hold_output || (!steady && $urandom_range(0, 99) < 37);
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// Reset sizes are 1x1x1: single element, index extremes, unused kind.
	task automatic test_reset_sizes();
		send_item(KIND_WRITE_A, 4'd0, 4'd0, 32'h3FC0_0000);
		send_item(KIND_WRITE_B, 4'd0, 4'd0, 32'hC000_0000);
		send_item(KIND_COMPUTE, 4'd0, 4'd0, 32'hFFFF_FFFF);
		send_item(KIND_WRITE_A, 4'd15, 4'd15, 32'hFFFF_FFFF);
		send_item(KIND_WRITE_B, 4'd0, 4'd15, 32'h0);
		send_item(KIND_COMPUTE, 4'd15, 4'd0, 32'h0);
		send_item(KIND_UNUSED, 4'd0, 4'd0, 32'h0);
	endtask

	task automatic two_term(logic [31:0] a0, logic [31:0] b0, logic [31:0] a1,
			logic [31:0] b1);
		send_item(KIND_WRITE_A, 4'd0, 4'd0, a0);
		send_item(KIND_WRITE_B, 4'd0, 4'd0, b0);
		send_item(KIND_WRITE_A, 4'd0, 4'd1, a1);
		send_item(KIND_WRITE_B, 4'd1, 4'd0, b1);
		send_item(KIND_COMPUTE, 4'd0, 4'd0, 32'h0);
	endtask

	// Two-term dot products on the special values.
	task automatic test_special_values();
		set_sizes(5'd1, 5'd2, 5'd1);
		two_term(FP_INF_MAG, 32'h0, 32'h3F80_0000, 32'h3F80_0000);     // inf times zero
		two_term(32'h7F7F_FFFF, 32'h4000_0000, 32'h0, 32'h0);          // overflow to inf
		two_term(32'h3F80_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000); // cancel
		two_term(32'h0000_0001, 32'h3F00_0000, 32'h8000_0003, 32'h3F80_0000); // subnormals
		two_term(32'h8000_0000, 32'h3F80_0000, FP_INF_MAG, 32'hFF80_0000);    // -0, -inf
		two_term(32'h7FA0_0001, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000); // NaN input
	endtask

	// Zero sizes, sizes above the store dimension, and the unused register index.
	task automatic test_size_limits();
		set_sizes(5'd2, 5'd0, 5'd2);
		send_item(KIND_WRITE_A, 4'd0, 4'd0, 32'h3F80_0000);
		send_item(KIND_WRITE_B, 4'd0, 4'd0, 32'h3F80_0000);
		send_item(KIND_COMPUTE, 4'd1, 4'd1, 32'h0);
		send_item(KIND_COMPUTE, 4'd2, 4'd0, 32'h0);
		write_size(REG_UNUSED, 5'd31);
		set_sizes(5'd0, 5'd1, 5'd0);
		send_item(KIND_COMPUTE, 4'd0, 4'd0, 32'h0);
		set_sizes(5'd31, 5'd31, 5'd31);
		// Last row of A and last column of B: a full-length dot product.
		for (int k = 0; k < DIM; k++) begin
			send_item(KIND_WRITE_A, 4'd15, 4'(k), random_single());
			send_item(KIND_WRITE_B, 4'(k), 4'd15, random_single());
		end
		send_item(KIND_COMPUTE, 4'd15, 4'd15, $urandom);
	endtask

	// Random mix of writes, computes, range errors and unused kinds.
	task automatic random_mix(int count);
		int sel;
		for (int c = 0; c < count; c++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40)
				send_item(($urandom_range(0, 1) != 0) ? KIND_WRITE_B : KIND_WRITE_A,
					4'($urandom_range(0, clamp_size(size_m) - 1)),
					4'($urandom_range(0, clamp_size(size_n) - 1)), random_single());
			else if (sel < 52)
				send_item(($urandom_range(0, 1) != 0) ? KIND_WRITE_B : KIND_WRITE_A,
					4'($urandom), 4'($urandom), $urandom);
			else if (sel < 82)
				send_item(KIND_COMPUTE, 4'($urandom_range(0, clamp_size(size_m) - 1)),
					4'($urandom_range(0, clamp_size(size_n) - 1)), $urandom);
			else if (sel < 95)
				send_item(KIND_COMPUTE, 4'($urandom), 4'($urandom), $urandom);
			else
				send_item(KIND_UNUSED, 4'($urandom), 4'($urandom), $urandom);
		end
	endtask

	// Several size settings, mostly small; one stretch without idling.
	task automatic test_random_phases();
		logic [4:0] shapes [8][3] = '{
			'{5'd3, 5'd4, 5'd2}, '{5'd1, 5'd16, 5'd1}, '{5'd5, 5'd1, 5'd7},
			'{5'd16, 5'd2, 5'd3}, '{5'd2, 5'd3, 5'd16}, '{5'd4, 5'd4, 5'd4},
			'{5'd6, 5'd5, 5'd3}, '{5'd2, 5'd8, 5'd2}};
		for (int p = 0; p < 8; p++) begin
			set_sizes(shapes[p][0], shapes[p][1], shapes[p][2]);
			steady = (p == 5);
			fill_operands();
			random_mix(20);
			steady = 1'b0;
		end
	endtask

	// Hold off the receiver for a long stretch while computes keep coming.
	task automatic test_backpressure();
		set_sizes(5'd3, 5'd2, 5'd3);
		fill_operands();
		fork
			begin
				hold_output = 1'b1;
				repeat (600) @(posedge clk);
				hold_output = 1'b0;
			end
			begin
				for (int c = 0; c < 20; c++)
					send_item(KIND_COMPUTE, 4'($urandom_range(0, 3)),
						4'($urandom_range(0, 3)), $urandom);
			end
		join
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_stall   = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_ROWS_M;
		cfg_data    = '0;
		steady      = 1'b0;
		hold_output = 1'b0;
		error_count = 0;
		size_m = 5'd1;
		size_k = 5'd1;
		size_n = 5'd1;
		for (int e = 0; e < DIM*DIM; e++) begin
			a_elems[e] = '0;
			b_elems[e] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_sizes();
		test_special_values();
		test_size_limits();
		test_random_phases();
		test_backpressure();

		// Drain, then give the block time to raise anything stray.
		go_quiet();
		while (pending_products.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/fmm_pkg.sv
sv/fmm_mul.sv
sv/fmm_align.sv
sv/fmm_norm.sv
sv/fmm_pack.sv
sv/float_matrix_multiply.sv
sv/fmm_checker.sv
tb/sv/testbench.sv
